// ===== rtl/sgpf_pkg.sv =====
// Shared widths, latencies, types and helper functions for the segment
// ground projection filter.
// No dependencies.
package sgpf_pkg;

  // field and register widths
  localparam int PIX_W   = 16;
  localparam int COEF_W  = 20;
  localparam int ROW_W   = 3 * COEF_W;
  localparam int LIMS_W  = 48;
  localparam int LIM_W   = 16;
  localparam int OUT_W   = 24;

  // datapath widths
  localparam int PROD_W  = COEF_W + PIX_W + 1;
  localparam int BEAR_W  = PROD_W + 1;
  localparam int MAG_W   = BEAR_W - 7;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = OUT_W + 4;

  // divider: numerator, denominator and clamped quotient widths
  localparam int DIV_NW  = BEAR_W + COEF_W;
  localparam int DIV_DW  = BEAR_W;
  localparam int DIV_QB  = 26;
  localparam int DIV_QW  = DIV_QB + 1;

  // pipeline depths
  localparam int DIV_LAT   = DIV_QB + 3;
  localparam int LANE_LAT  = DIV_LAT + 4;
  localparam int FLT_LAT   = DIV_LAT + 3;
  localparam int TOTAL_LAT = LANE_LAT + FLT_LAT;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [OUT_W-1:0]  coord_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } seg_t;

  // pick one signed coefficient out of a packed row register
  function automatic coef_t coef_at(input logic [ROW_W-1:0] r, input int i);
    return r[i*COEF_W +: COEF_W];
  endfunction

  // saturate a widened sum to the output coordinate range
  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    coord_t res;
    if ((&v[SUM_W-1:OUT_W-1]) || (~|v[SUM_W-1:OUT_W-1])) begin
      res = v[OUT_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ===== rtl/segment_ground_projection_filter_top.sv =====
// Segment ground projection filter, top level: configuration registers,
// stream handshake, two endpoint lanes and the merging filter.
// Depends on sgpf_pkg, sgpf_lane, sgpf_flt and sgpf_div.
//
// Takes one image line segment per transfer and returns its ground plane
// projection, or nothing when the segment is filtered out. The pipeline
// accepts a new segment every cycle unless it holds; a kept segment passes
// through two one-bit-per-stage dividers in series (ground intersection in
// the lanes, then the distance cut in the filter). The whole pipeline holds
// only while a result waits in the output register and another kept one
// reaches the end.
module segment_ground_projection_filter_top import sgpf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // configuration writes
  input  logic                    cfg_wr_en,
  input  logic [2:0]              cfg_index,
  input  logic [ROW_W-1:0]        cfg_data,
  // input segments
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [4*PIX_W-1:0]      s_tdata,  // start_col, start_row, end_col, end_row
  input  logic                    s_tuser,  // inside_mask
  // output segments
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [4*OUT_W-1:0]      m_tdata,  // start_x, start_y, end_x, end_y
  output logic                    m_tuser   // was_truncated
);

  localparam logic [2:0] REG_ROW_X  = 3'd0;
  localparam logic [2:0] REG_ROW_Y  = 3'd1;
  localparam logic [2:0] REG_ROW_Z  = 3'd2;
  localparam logic [2:0] REG_CAM    = 3'd3;
  localparam logic [2:0] REG_LIMITS = 3'd4;
  localparam logic [2:0] REG_SELECT = 3'd5;

  logic [ROW_W-1:0]     row_x, row_y, row_z, cam;
  logic [LIMS_W-1:0]    limits;
  logic                 sel_out;

  logic                 en;
  logic [TOTAL_LAT-1:0] vpipe;
  coord_t               g1x, g1y, g2x, g2y;
  logic                 ok1, ok2;
  seg_t                 seg_mid;
  seg_t                 seg_fin;
  logic                 keep_fin, trunc_fin;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_x   <= '0;
      row_y   <= '0;
      row_z   <= '0;
      cam     <= '0;
      limits  <= '0;
      sel_out <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROW_X:  row_x   <= cfg_data;
        REG_ROW_Y:  row_y   <= cfg_data;
        REG_ROW_Z:  row_z   <= cfg_data;
        REG_CAM:    cam     <= cfg_data;
        REG_LIMITS: limits  <= cfg_data[LIMS_W-1:0];
        REG_SELECT: sel_out <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless a kept result would overwrite a waiting one
  assign en       = !m_tvalid || m_tready || !(vpipe[TOTAL_LAT-1] && keep_fin);
  assign s_tready = en;

  // valid line, mask selection folded in at entry
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[TOTAL_LAT-2:0], s_tvalid && (s_tuser != sel_out)};
    end
  end

  // endpoint lanes
  sgpf_lane u_lane_start (
    .clk   (clk),
    .en    (en),
    .col   (s_tdata[PIX_W-1:0]),
    .row   (s_tdata[2*PIX_W-1:PIX_W]),
    .row_x (row_x),
    .row_y (row_y),
    .row_z (row_z),
    .cam   (cam),
    .gx    (g1x),
    .gy    (g1y),
    .ok    (ok1)
  );

  sgpf_lane u_lane_end (
    .clk   (clk),
    .en    (en),
    .col   (s_tdata[3*PIX_W-1:2*PIX_W]),
    .row   (s_tdata[4*PIX_W-1:3*PIX_W]),
    .row_x (row_x),
    .row_y (row_y),
    .row_z (row_z),
    .cam   (cam),
    .gx    (g2x),
    .gy    (g2y),
    .ok    (ok2)
  );

  assign seg_mid = '{x1: g1x, y1: g1y, x2: g2x, y2: g2y};

  // segment tests and distance cut
  sgpf_flt u_flt (
    .clk     (clk),
    .en      (en),
    .seg_in  (seg_mid),
    .ok_in   (ok1 && ok2),
    .limits  (limits),
    .seg_out (seg_fin),
    .keep    (keep_fin),
    .trunc   (trunc_fin)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      if (vpipe[TOTAL_LAT-1] && keep_fin) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && vpipe[TOTAL_LAT-1] && keep_fin) begin
      m_tdata <= {seg_fin.y2, seg_fin.x2, seg_fin.y1, seg_fin.x1};
      m_tuser <= trunc_fin;
    end
  end

endmodule

// ===== rtl/sgpf_div.sv =====
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero and clamping the quotient magnitude. Depends on sgpf_pkg.
module sgpf_div import sgpf_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DIV_NW-1:0] num,
  input  logic signed [DIV_DW-1:0] den,
  output logic signed [DIV_QW-1:0] quot
);

  logic              neg0;
  logic [DIV_NW-1:0] nm0;
  logic [DIV_DW-1:0] dm0;

  logic [DIV_DW-1:0] rem  [DIV_QB+1];
  logic [DIV_QB-1:0] qacc [DIV_QB+1];
  logic [DIV_QB-1:0] lo   [DIV_QB+1];
  logic [DIV_DW-1:0] dm   [DIV_QB+1];
  logic              neg  [DIV_QB+1];
  logic              ovf  [DIV_QB+1];

  logic [DIV_QB-1:0] qmag;

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    if (en) begin
      neg0 <= num[DIV_NW-1] ^ den[DIV_DW-1];
      nm0  <= num[DIV_NW-1] ? -num : num;
      dm0  <= den[DIV_DW-1] ? -den : den;
    end
  end

  // overflow check and first partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      ovf[0]  <= DIV_DW'(nm0[DIV_NW-1:DIV_QB]) >= dm0;
      rem[0]  <= DIV_DW'(nm0[DIV_NW-1:DIV_QB]);
      lo[0]   <= nm0[DIV_QB-1:0];
      qacc[0] <= '0;
      dm[0]   <= dm0;
      neg[0]  <= neg0;
    end
  end

  // restoring iterations
  for (genvar k = 0; k < DIV_QB; k++) begin : g_step
    logic [DIV_DW:0] trial;
    logic [DIV_DW:0] diff;
    logic            ge;

    assign trial = {rem[k], lo[k][DIV_QB-1-k]};
    assign diff  = trial - {1'b0, dm[k]};
    assign ge    = trial >= {1'b0, dm[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        qacc[k+1] <= qacc[k] | (DIV_QB'(ge) << (DIV_QB-1-k));
        lo[k+1]   <= lo[k];
        dm[k+1]   <= dm[k];
        neg[k+1]  <= neg[k];
        ovf[k+1]  <= ovf[k];
      end
    end
  end

  // clamp and restore sign
  assign qmag = ovf[DIV_QB] ? '1 : qacc[DIV_QB];

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= neg[DIV_QB] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    end
  end

endmodule

// ===== rtl/sgpf_lane.sv =====
// One endpoint lane: bearing through the matrix rows, elevation test and
// ground plane intersection. Depends on sgpf_pkg and sgpf_div.
module sgpf_lane import sgpf_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [PIX_W-1:0] col,
  input  logic [PIX_W-1:0] row,
  input  logic [ROW_W-1:0] row_x,
  input  logic [ROW_W-1:0] row_y,
  input  logic [ROW_W-1:0] row_z,
  input  logic [ROW_W-1:0] cam,
  output coord_t           gx,
  output coord_t           gy,
  output logic             ok
);

  localparam logic signed [BEAR_W-1:0] BZ_LIM = -64;
  localparam logic [13:0] ELEV_K = 14'd9999;
  localparam int OK_DLY = LANE_LAT - 6;

  logic signed [PIX_W:0]     u;
  logic signed [PIX_W:0]     v;
  logic signed [PROD_W-1:0]  pxu, pxv, pyu, pyv, pzu, pzv;
  logic signed [BEAR_W-1:0]  bx, by, bz;
  logic signed [BEAR_W-1:0]  bz3;
  logic signed [DIV_NW-1:0]  nx, ny;
  logic [BEAR_W-1:0]         abx, aby, abz;
  logic [MAG_W-1:0]          ax, ay, az;
  logic                      neg3, neg4, neg5;
  logic [SQ_W-1:0]           sqx, sqy, sqz;
  logic [SQ_W:0]             s5;
  logic [SQ_W+13:0]          z9;
  logic                      ok6;
  logic                      okd [OK_DLY];
  logic signed [DIV_QW-1:0]  qx, qy;

  assign u = {1'b0, col};
  assign v = {1'b0, row};

  // coefficient products
  always_ff @(posedge clk) begin
    if (en) begin
      pxu <= coef_at(row_x, 0) * u;
      pxv <= coef_at(row_x, 1) * v;
      pyu <= coef_at(row_y, 0) * u;
      pyv <= coef_at(row_y, 1) * v;
      pzu <= coef_at(row_z, 0) * u;
      pzv <= coef_at(row_z, 1) * v;
    end
  end

  // bearing sums, constant term scaled to Q.22
  always_ff @(posedge clk) begin
    if (en) begin
      bx <= BEAR_W'(pxu) + BEAR_W'(pxv) + (BEAR_W'(coef_at(row_x, 2)) <<< 4);
      by <= BEAR_W'(pyu) + BEAR_W'(pyv) + (BEAR_W'(coef_at(row_y, 2)) <<< 4);
      bz <= BEAR_W'(pzu) + BEAR_W'(pzv) + (BEAR_W'(coef_at(row_z, 2)) <<< 4);
    end
  end

  // magnitudes truncated to Q.16, and products with camera height
  assign abx = bx[BEAR_W-1] ? -bx : bx;
  assign aby = by[BEAR_W-1] ? -by : by;
  assign abz = bz[BEAR_W-1] ? -bz : bz;

  always_ff @(posedge clk) begin
    if (en) begin
      ax   <= abx[BEAR_W-2:6];
      ay   <= aby[BEAR_W-2:6];
      az   <= abz[BEAR_W-2:6];
      neg3 <= bz <= BZ_LIM;
      nx   <= bx * coef_at(cam, 2);
      ny   <= by * coef_at(cam, 2);
      bz3  <= bz;
    end
  end

  // elevation test: 9999 * z^2 >= x^2 + y^2
  always_ff @(posedge clk) begin
    if (en) begin
      sqx  <= ax * ax;
      sqy  <= ay * ay;
      sqz  <= az * az;
      neg4 <= neg3;
      s5   <= (SQ_W+1)'(sqx) + (SQ_W+1)'(sqy);
      z9   <= sqz * ELEV_K;
      neg5 <= neg4;
      ok6  <= neg5 && (z9 >= (SQ_W+14)'(s5));
    end
  end

  // hold the test result until the ground point is ready
  always_ff @(posedge clk) begin
    if (en) begin
      okd[0] <= ok6;
    end
  end

  for (genvar j = 1; j < OK_DLY; j++) begin : g_okd
    always_ff @(posedge clk) begin
      if (en) begin
        okd[j] <= okd[j-1];
      end
    end
  end

  assign ok = okd[OK_DLY-1];

  // b.xy * t.z / b.z
  sgpf_div u_div_x (
    .clk  (clk),
    .en   (en),
    .num  (nx),
    .den  (bz3),
    .quot (qx)
  );

  sgpf_div u_div_y (
    .clk  (clk),
    .en   (en),
    .num  (ny),
    .den  (bz3),
    .quot (qy)
  );

  // ground point, saturated
  always_ff @(posedge clk) begin
    if (en) begin
      gx <= sat_coord(SUM_W'(coef_at(cam, 0)) - SUM_W'(qx));
      gy <= sat_coord(SUM_W'(coef_at(cam, 1)) - SUM_W'(qy));
    end
  end

endmodule

// ===== rtl/sgpf_flt.sv =====
// Merging stage: combines both lanes, applies length, lateral and distance
// tests and cuts the far endpoint back. Depends on sgpf_pkg and sgpf_div.
module sgpf_flt import sgpf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  seg_t              seg_in,
  input  logic              ok_in,
  input  logic [LIMS_W-1:0] limits,
  output seg_t              seg_out,
  output logic              keep,
  output logic              trunc
);

  localparam int DL_W  = LIM_W + 4;
  localparam int DX_W  = OUT_W + 1;
  localparam int NUM_W = OUT_W + 2;
  localparam int PX_W  = NUM_W + DX_W;
  localparam int INFO_DLY = FLT_LAT - 3;
  localparam logic signed [DX_W-1:0] EPS  = 4;
  localparam logic signed [DX_W-1:0] NEPS = -4;

  typedef struct packed {
    seg_t seg;
    logic keep;
    logic cut;
    logic start_far;
  } info_t;

  logic [DL_W-1:0]          ml, ll, dd;
  logic signed [DX_W-1:0]   x1e, x2e, de;
  logic [OUT_W-1:0]         a1, a2;

  seg_t                     seg1, seg2;
  logic                     ok1, ok2;
  logic                     far1, far2, lat1, lat2, cut1, cut2, sf1, sf2;
  logic signed [DX_W-1:0]   dx1, dy1;
  logic signed [NUM_W-1:0]  num1;
  logic [DL_W-1:0]          ml1;
  logic signed [DX_W-1:0]   e2;
  logic [2*DX_W-1:0]        pdx2, pdy2;
  logic signed [PX_W-1:0]   cx2, cy2;
  logic [2*DL_W-1:0]        ml2;
  info_t                    info [INFO_DLY];
  info_t                    last;
  logic signed [DIV_QW-1:0] qx, qy;
  coord_t                   mx, my;
  seg_t                     cut_seg;

  assign ml  = {limits[LIM_W-1:0], 4'b0};
  assign ll  = {limits[2*LIM_W-1:LIM_W], 4'b0};
  assign dd  = {limits[3*LIM_W-1:2*LIM_W], 4'b0};
  assign x1e = DX_W'(seg_in.x1);
  assign x2e = DX_W'(seg_in.x2);
  assign de  = $signed({{(DX_W-DL_W){1'b0}}, dd});
  assign a1  = seg_in.y1[OUT_W-1] ? -seg_in.y1 : seg_in.y1;
  assign a2  = seg_in.y2[OUT_W-1] ? -seg_in.y2 : seg_in.y2;

  // differences and threshold flags
  always_ff @(posedge clk) begin
    if (en) begin
      seg1 <= seg_in;
      ok1  <= ok_in;
      dx1  <= x1e - x2e;
      dy1  <= DX_W'(seg_in.y1) - DX_W'(seg_in.y2);
      num1 <= NUM_W'(de) - NUM_W'(x1e);
      far1 <= (dd != '0) && (x1e > de) && (x2e > de);
      cut1 <= (dd != '0) && ((x1e >= de) || (x2e >= de));
      lat1 <= (ll != '0) && (a1 > OUT_W'(ll)) && (a2 > OUT_W'(ll));
      sf1  <= seg_in.x1 > seg_in.x2;
      ml1  <= ml;
    end
  end

  // squares, cut products and divisor kept away from zero
  always_ff @(posedge clk) begin
    if (en) begin
      seg2 <= seg1;
      ok2  <= ok1;
      far2 <= far1;
      cut2 <= cut1;
      lat2 <= lat1;
      sf2  <= sf1;
      pdx2 <= dx1 * dx1;
      pdy2 <= dy1 * dy1;
      cx2  <= num1 * dx1;
      cy2  <= num1 * dy1;
      ml2  <= ml1 * ml1;
      if (dx1 > 0) begin
        e2 <= (dx1 > EPS) ? dx1 : EPS;
      end else begin
        e2 <= (dx1 < NEPS) ? dx1 : NEPS;
      end
    end
  end

  // length test and combined keep decision
  always_ff @(posedge clk) begin
    if (en) begin
      info[0].seg       <= seg2;
      info[0].keep      <= ok2 && !far2 && !lat2 &&
                           !((ml2 != '0) &&
                             ((PX_W'(pdx2) + PX_W'(pdy2)) < PX_W'(ml2)));
      info[0].cut       <= cut2;
      info[0].start_far <= sf2;
    end
  end

  for (genvar j = 1; j < INFO_DLY; j++) begin : g_info
    always_ff @(posedge clk) begin
      if (en) begin
        info[j] <= info[j-1];
      end
    end
  end

  assign last = info[INFO_DLY-1];

  // d * (D - start.x) / e
  sgpf_div u_div_x (
    .clk  (clk),
    .en   (en),
    .num  (DIV_NW'(cx2)),
    .den  (DIV_DW'(e2)),
    .quot (qx)
  );

  sgpf_div u_div_y (
    .clk  (clk),
    .en   (en),
    .num  (DIV_NW'(cy2)),
    .den  (DIV_DW'(e2)),
    .quot (qy)
  );

  assign mx = sat_coord(SUM_W'(last.seg.x1) + SUM_W'(qx));
  assign my = sat_coord(SUM_W'(last.seg.y1) + SUM_W'(qy));

  // replace the far endpoint when cut
  always_comb begin
    cut_seg = last.seg;
    if (last.cut) begin
      if (last.start_far) begin
        cut_seg.x1 = mx;
        cut_seg.y1 = my;
      end else begin
        cut_seg.x2 = mx;
        cut_seg.y2 = my;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_out <= cut_seg;
      keep    <= last.keep;
      trunc   <= last.cut;
    end
  end

endmodule

// ===== tb/tb_segment_ground_projection_filter_top.sv =====
// Self-checking testbench for segment_ground_projection_filter_top: random camera setups,
// segment streams with random idling on both sides, and a scoreboard that predicts each result.
// Depends on sgpf_pkg and the top level RTL.
module tb_segment_ground_projection_filter_top import sgpf_pkg::*;;

  // configuration register indexes
  localparam logic [2:0] REG_ROW_X   = 3'd0;
  localparam logic [2:0] REG_ROW_Y   = 3'd1;
  localparam logic [2:0] REG_ROW_Z   = 3'd2;
  localparam logic [2:0] REG_OFFSET  = 3'd3;
  localparam logic [2:0] REG_LIMITS  = 3'd4;
  localparam logic [2:0] REG_SELECT  = 3'd5;
  localparam int DRAIN_CYCLES = TOTAL_LAT + 20;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [15:0] scol, srow, ecol, erow;
    logic        mask;
  } seg_in_t;

  typedef struct {
    logic [23:0] sx, sy, ex, ey;
    logic        cut;
  } ground_seg_t;

  // ground projection predictor and store of expected segments
  class ground_scoreboard;
    logic [59:0]  row_x, row_y, row_z, offset;
    logic [47:0]  limits;
    logic         outside;
    ground_seg_t  expected_q[$];
    int           errors;

    function void set_reg(logic [2:0] idx, logic [59:0] val);
      case (idx)
        REG_ROW_X:  row_x = val;
        REG_ROW_Y:  row_y = val;
        REG_ROW_Z:  row_z = val;
        REG_OFFSET: offset = val;
        REG_LIMITS: limits = val[47:0];
        REG_SELECT: outside = val[0];
        default: ;
      endcase
    endfunction

    function longint coef(logic [59:0] r, int i);
      logic signed [19:0] c;
      c = r[i*20 +: 20];
      return longint'(c);
    endfunction

    function longint sat(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function longint dot(logic [59:0] r, longint u, longint v);
      return coef(r, 0) * u + coef(r, 1) * v + coef(r, 2) * 16;
    endfunction

    // bearing, elevation test and ground intersection of one endpoint
    function bit project(logic [15:0] col, logic [15:0] row, output longint gx,
                         output longint gy);
      longint u, v, bx, by, bz, rx, ry, rz, tz;
      longint unsigned s, zz;
      gx = 0;
      gy = 0;
      u = longint'(col);
      v = longint'(row);
      bx = dot(row_x, u, v);
      by = dot(row_y, u, v);
      bz = dot(row_z, u, v);
      rx = bx / 64;
      ry = by / 64;
      rz = bz / 64;
      if (rz >= 0) return 0;
      s = longint'(rx * rx) + longint'(ry * ry);
      zz = rz * rz;
      if (zz < (s + 9998) / 9999) return 0;
      tz = coef(offset, 2);
      gx = sat(coef(offset, 0) - (bx * tz) / bz);
      gy = sat(coef(offset, 1) - (by * tz) / bz);
      return 1;
    endfunction

    // note an accepted segment and queue its expected result, if any
    function void note_segment(seg_in_t it);
      longint x1, y1, x2, y2, min_len, max_lat, max_dst, dx, dy, a1, a2, lo, hi;
      longint e, num, mx, my;
      ground_seg_t r;
      min_len = longint'(limits[15:0]) << 4;
      max_lat = longint'(limits[31:16]) << 4;
      max_dst = longint'(limits[47:32]) << 4;
      r.cut = 0;
      if (it.mask == outside) return;
      if (!project(it.scol, it.srow, x1, y1)) return;
      if (!project(it.ecol, it.erow, x2, y2)) return;
      if (min_len > 0) begin
        dx = x1 - x2;
        dy = y1 - y2;
        if (dx * dx + dy * dy < min_len * min_len) return;
      end
      if (max_lat > 0) begin
        a1 = y1 < 0 ? -y1 : y1;
        a2 = y2 < 0 ? -y2 : y2;
        if ((a1 < a2 ? a1 : a2) > max_lat) return;
      end
      if (max_dst > 0) begin
        lo = x1 < x2 ? x1 : x2;
        hi = x1 < x2 ? x2 : x1;
        if (lo > max_dst) return;
        if (hi >= max_dst) begin
          dx = x1 - x2;
          dy = y1 - y2;
          if (dx > 0) e = dx > 4 ? dx : 4;
          else e = dx < -4 ? dx : -4;
          num = max_dst - x1;
          mx = sat(x1 + (num * dx) / e);
          my = sat(y1 + (num * dy) / e);
          if (x1 > x2) begin
            x1 = mx;
            y1 = my;
          end else begin
            x2 = mx;
            y2 = my;
          end
          r.cut = 1;
        end
      end
      r.sx = x1[23:0];
      r.sy = y1[23:0];
      r.ex = x2[23:0];
      r.ey = y2[23:0];
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report(string what, logic [23:0] got, logic [23:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
      errors++;
    endtask

    // compare one output transfer with the oldest expectation
    task check_segment(logic [4*OUT_W-1:0] data, logic cut);
      ground_seg_t w;
      if (expected_q.size() == 0) begin
        report("unexpected segment", data[23:0], 24'h0);
        return;
      end
      w = expected_q.pop_front();
      if (data[23:0] !== w.sx) report("start_x", data[23:0], w.sx);
      if (data[47:24] !== w.sy) report("start_y", data[47:24], w.sy);
      if (data[71:48] !== w.ex) report("end_x", data[71:48], w.ex);
      if (data[95:72] !== w.ey) report("end_y", data[95:72], w.ey);
      if (cut !== w.cut) report("was_truncated", 24'(cut), 24'(w.cut));
    endtask
  endclass

  logic              clk = 0;
  logic              rst = 1;
  logic              cfg_wr_en = 0;
  logic [2:0]        cfg_index = REG_ROW_X;
  logic [ROW_W-1:0]  cfg_data = '0;
  logic              s_tvalid = 0;
  logic              s_tready;
  logic [63:0]       s_tdata = '0;
  logic              s_tuser = 0;
  logic              m_tvalid;
  logic              m_tready = 0;
  logic [95:0]       m_tdata;
  logic              m_tuser;

  ground_scoreboard sb = new();
  bit      idle_on = 1;
  bit      hold_req = 0;
  int      cycles = 0;
  int      horizon = 0;

  segment_ground_projection_filter_top u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // output side: check transfers, random stalls and one long hold-off
  initial begin
    int stall_cnt, hold_cnt;
    stall_cnt = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_segment(m_tdata, m_tuser);
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        m_tready <= 0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_cnt = $urandom_range(0, 18);
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  task cfg_write(logic [2:0] idx, logic [59:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  function logic [59:0] pack3(int a, int b, int c);
    logic [19:0] pa, pb, pc;
    pa = a[19:0];
    pb = b[19:0];
    pc = c[19:0];
    return {pc, pb, pa};
  endfunction

  function logic [59:0] rand60();
    return 60'({$urandom(), $urandom()});
  endfunction

  // forward-looking camera: bearing z goes negative below a random horizon
  task setup_camera(logic [47:0] lims, logic sel);
    int rl, rz;
    rl = $urandom_range(16, 200);
    rz = $urandom_range(16, 200);
    horizon = $urandom_range(0, 40000);
    cfg_write(REG_ROW_X, pack3(int'($urandom_range(0, 64)) - 32, 0,
                               int'($urandom_range(65536, 262143))));
    cfg_write(REG_ROW_Y, pack3(-rl, int'($urandom_range(0, 16)) - 8, rl * 2048));
    cfg_write(REG_ROW_Z, pack3(int'($urandom_range(0, 16)) - 8, -rz, (rz * horizon) / 16));
    cfg_write(REG_OFFSET, pack3(int'($urandom_range(0, 8192)) - 4096,
                                int'($urandom_range(0, 4096)) - 2048,
                                int'($urandom_range(2048, 16384))));
    cfg_write(REG_LIMITS, (rand60() & 60'hFFF_0000_0000_0000) | 60'(lims));
    cfg_write(REG_SELECT, (rand60() & 60'hFFF_FFFF_FFFF_FFFE) | 60'(sel));
    cfg_wr_en <= 0;
  endtask

  function logic [47:0] rand_limits();
    logic [15:0] ml, lat, dst;
    ml = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 200));
    lat = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(64, 2000));
    dst = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(16, 4000));
    return {dst, lat, ml};
  endfunction

  task send_segment(seg_in_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {it.erow, it.ecol, it.srow, it.scol};
    s_tuser <= it.mask;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_segment(it);
  endtask

  // random segment, mostly in front of the camera with the selected mask value
  function seg_in_t rand_segment();
    seg_in_t it;
    if ($urandom_range(0, 3) == 0) begin
      it.scol = 16'($urandom());
      it.srow = 16'($urandom());
      it.ecol = 16'($urandom());
      it.erow = 16'($urandom());
      it.mask = 1'($urandom());
    end else begin
      it.scol = 16'($urandom());
      it.srow = 16'($urandom_range(horizon, 65535));
      it.ecol = 16'($urandom());
      it.erow = 16'($urandom_range(horizon, 65535));
      it.mask = ($urandom_range(0, 7) == 0) ? sb.outside : ~sb.outside;
    end
    return it;
  endfunction

  task drain();
    s_tvalid <= 0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    seg_in_t it;
    int phase;
    sb.row_x = 0; sb.row_y = 0; sb.row_z = 0; sb.offset = 0;
    sb.limits = 0; sb.outside = 0;
    sb.errors = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset configuration: zero bearings fail everywhere
    for (int i = 0; i < 6; i++) begin
      it = '{16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()), 1'(i)};
      send_segment(it);
    end
    drain();

    // directed corners, degenerate and mask cases
    setup_camera({16'd1200, 16'd1500, 16'd40}, 0);
    it = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}; send_segment(it);
    it = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}; send_segment(it);
    it = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}; send_segment(it);
    it = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1}; send_segment(it);
    it = '{16'h8000, 16'hFFFF, 16'h8000, 16'hF000, 1'b1}; send_segment(it);
    it = '{16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b1}; send_segment(it);
    it = '{16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b0}; send_segment(it);
    it = '{16'h4000, 16'hFFF0, 16'hC000, 16'hFFF0, 1'b1}; send_segment(it);
    it = '{16'h8000, 16'hA000, 16'h8000, 16'hFFFF, 1'b1}; send_segment(it);
    it = '{16'h8000, 16'hFFFF, 16'h8000, 16'hA000, 1'b1}; send_segment(it);
    it = '{16'h0000, 16'h0000, 16'h8000, 16'hFFFF, 1'b1}; send_segment(it);
    drain();
    setup_camera(48'd0, 1);
    it = '{16'h8000, 16'hFFFF, 16'h8000, 16'hC000, 1'b0}; send_segment(it);
    it = '{16'h8000, 16'hFFFF, 16'h8000, 16'hC000, 1'b1}; send_segment(it);
    it = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}; send_segment(it);
    drain();

    // extreme register contents
    for (int i = 0; i < 6; i++) cfg_write(3'(i), {60{1'b1}});
    cfg_wr_en <= 0;
    for (int i = 0; i < 10; i++) send_segment(rand_segment());
    drain();
    cfg_write(REG_ROW_X, {3{20'h7FFFF}});
    cfg_write(REG_ROW_Y, {3{20'h80000}});
    cfg_write(REG_ROW_Z, {20'h80000, 20'h80000, 20'h00000});
    cfg_write(REG_OFFSET, {20'h7FFFF, 20'h80000, 20'h7FFFF});
    cfg_write(REG_LIMITS, 60'hFFFF_FFFF_FFFF);
    cfg_write(REG_SELECT, 60'd0);
    cfg_wr_en <= 0;
    for (int i = 0; i < 20; i++) send_segment(rand_segment());
    drain();

    // random phases; the last runs without idling
    phase = 0;
    while (phase < 9) begin
      if (phase % 4 == 3) begin
        for (int i = 0; i < 6; i++) cfg_write(3'(i), rand60());
        cfg_wr_en <= 0;
      end else begin
        setup_camera(rand_limits(), 1'($urandom()));
      end
      idle_on = (phase < 8);
      for (int i = 0; i < 180; i++) begin
        if (phase == 2 && i == 20) hold_req = 1;
        if (phase == 4 && i == 90) begin
          s_tvalid <= 0;
          @(posedge clk);
          while (sb.expected_q.size() > 0) @(posedge clk);
        end
        send_segment(rand_segment());
      end
      drain();
      phase++;
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
